/* rtl/core/pwa_pkg.sv */
// ----------------------------------------------------------------------------
// pwa_pkg
// Shared types, sizes and term-order helpers for the polynomial warp stacker.
// ----------------------------------------------------------------------------
`default_nettype none

package pwa_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int DEGREE     = 2;
	localparam int PIXEL_BITS = 16;

	localparam int NTERMS     = (DEGREE + 1) * (DEGREE + 2) / 2;
	localparam int NPIX       = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_BITS  = $clog2(NPIX);
	localparam int COL_BITS   = $clog2(MAX_WIDTH);
	localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
	localparam int CNT_BITS   = $clog2(NPIX + 1);

	localparam int FIELD_BITS = 8;                        // col / row field width
	localparam int COEF_BITS  = 40;
	localparam int FRAC_BITS  = 24;
	localparam int MONO_BITS  = DEGREE * FIELD_BITS;      // col^i * row^j
	localparam int PROD_BITS  = COEF_BITS + MONO_BITS + 1;
	localparam int SUM_BITS   = PROD_BITS + $clog2(NTERMS + 1);
	localparam int COORD_BITS = SUM_BITS - FRAC_BITS;
	localparam int SIZE_BITS  = 9;                        // active size registers
	localparam int SUM_W      = 32;

	// accept edge to the edge that samples the result strobe
	localparam int LATENCY    = 8;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_COEF  = 2'd1,
		REQ_ACCUM = 2'd2,
		REQ_READ  = 2'd3
	} req_t;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		req_t                         req_type;
		logic [7:0]                   col;
		logic [7:0]                   row;
		logic [15:0]                  pixel_value;
		logic                         coef_axis;
		logic [3:0]                   coef_index;
		logic signed [COEF_BITS-1:0]  coef_value;
	} cmd_t;

	typedef struct packed {
		logic [SUM_W-1:0] pixel_sum;
		logic             source_used;
		logic             sum_saturated;
	} result_t;

	// warp pipeline -> store stages
	typedef struct packed {
		logic                  valid;
		req_t                  req_type;
		logic                  addr_ok;
		logic [ADDR_BITS-1:0]  addr;
		logic [PIXEL_BITS-1:0] pixel_value;
		logic                  in_frame;
		logic [ADDR_BITS-1:0]  src_addr;
	} warp_out_t;

	// exponent of col for term t (i outer, j inner)
	function automatic int term_i(input int t);
		int n;
		int r;
		n = 0;
		r = 0;
		for (int i = 0; i <= DEGREE; i++) begin
			for (int j = 0; j <= DEGREE - i; j++) begin
				if (n == t) r = i;
				n++;
			end
		end
		return r;
	endfunction

	// exponent of row for term t
	function automatic int term_j(input int t);
		int n;
		int r;
		n = 0;
		r = 0;
		for (int i = 0; i <= DEGREE; i++) begin
			for (int j = 0; j <= DEGREE - i; j++) begin
				if (n == t) r = j;
				n++;
			end
		end
		return r;
	endfunction

	// exact fixed-point sum -> integer, truncated toward zero
	function automatic logic signed [COORD_BITS-1:0] trunc_coord(
		input logic signed [SUM_BITS-1:0] s);
		logic signed [COORD_BITS-1:0] q;
		q = $signed(s[SUM_BITS-1:FRAC_BITS]);
		if (s[SUM_BITS-1] && (s[FRAC_BITS-1:0] != '0)) q = q + COORD_BITS'(1);
		return q;
	endfunction

	function automatic logic coord_ok(input logic signed [COORD_BITS-1:0] q,
		input logic [SIZE_BITS-1:0] lim);
		return !q[COORD_BITS-1] && ($unsigned(q) < COORD_BITS'(lim));
	endfunction

endpackage

`default_nettype wire

/* rtl/core/pwa_ram.sv */
// ----------------------------------------------------------------------------
// pwa_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module pwa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

/* rtl/core/pwa_warp.sv */
// ----------------------------------------------------------------------------
// pwa_warp
// Coefficient registers and the six-stage polynomial pipeline that maps an
// output pixel to its source pixel and frame check.
// ----------------------------------------------------------------------------
`default_nettype none

module pwa_warp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire pwa_pkg::cmd_t                      cmd,
	input  wire logic [pwa_pkg::SIZE_BITS-1:0]      frame_w,
	input  wire logic [pwa_pkg::SIZE_BITS-1:0]      frame_h,
	output pwa_pkg::warp_out_t                      wout
);

	localparam int MB = pwa_pkg::MONO_BITS;
	localparam int PB = pwa_pkg::PROD_BITS;
	localparam int SB = pwa_pkg::SUM_BITS;
	localparam int CB = pwa_pkg::COORD_BITS;
	localparam int NT = pwa_pkg::NTERMS;
	localparam int DG = pwa_pkg::DEGREE;

	typedef struct packed {
		pwa_pkg::req_t                  req_type;
		logic [7:0]                     col;
		logic [7:0]                     row;
		logic [pwa_pkg::PIXEL_BITS-1:0] pixel_value;
	} tag_t;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4, tag_s5;

	// coefficient fields ride to s2; the write lands on the edge that loads
	// s3, so every word ahead has already taken its products
	logic                                 cax_s1, cax_s2;
	logic [3:0]                           cix_s1, cix_s2;
	logic signed [pwa_pkg::COEF_BITS-1:0] cval_s1, cval_s2;

	// coefficient registers
	logic signed [pwa_pkg::COEF_BITS-1:0] x_coef_q [NT];
	logic signed [pwa_pkg::COEF_BITS-1:0] y_coef_q [NT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NT; t++) begin
				x_coef_q[t] <= '0;
				y_coef_q[t] <= '0;
			end
		end else if (v_s2 && tag_s2.req_type == pwa_pkg::REQ_COEF
			&& 32'(cix_s2) < NT) begin
			for (int t = 0; t < NT; t++) begin
				if (32'(cix_s2) == t) begin
					if (cax_s2) y_coef_q[t] <= cval_s2;
					else x_coef_q[t] <= cval_s2;
				end
			end
		end
	end

	// powers of col and row
	logic [DG:0][MB-1:0] pc_c, pr_c;

	always_comb begin
		pc_c[0] = MB'(1);
		pr_c[0] = MB'(1);
		for (int k = 1; k <= DG; k++) begin
			pc_c[k] = MB'(pc_c[k-1] * cmd.col);
			pr_c[k] = MB'(pr_c[k-1] * cmd.row);
		end
	end

	logic [DG:0][MB-1:0] pc_s1, pr_s1;
	logic [MB-1:0] mono_s2 [NT];
	logic signed [PB-1:0] px_s3 [NT];
	logic signed [PB-1:0] py_s3 [NT];
	logic signed [SB-1:0] gx_s4 [DG+1];
	logic signed [SB-1:0] gy_s4 [DG+1];
	logic signed [SB-1:0] sx_s5, sy_s5;

	logic signed [SB-1:0] gx_c [DG+1];
	logic signed [SB-1:0] gy_c [DG+1];
	logic signed [SB-1:0] sx_c, sy_c;

	// per-i group sums
	always_comb begin
		for (int i = 0; i <= DG; i++) begin
			gx_c[i] = '0;
			gy_c[i] = '0;
		end
		for (int t = 0; t < NT; t++) begin
			gx_c[pwa_pkg::term_i(t)] = gx_c[pwa_pkg::term_i(t)] + SB'(px_s3[t]);
			gy_c[pwa_pkg::term_i(t)] = gy_c[pwa_pkg::term_i(t)] + SB'(py_s3[t]);
		end
	end

	always_comb begin
		sx_c = '0;
		sy_c = '0;
		for (int i = 0; i <= DG; i++) begin
			sx_c = sx_c + gx_s4[i];
			sy_c = sy_c + gy_s4[i];
		end
	end

	logic signed [CB-1:0] qx_c, qy_c;
	logic                 addr_ok_c;

	assign qx_c = pwa_pkg::trunc_coord(sx_s5);
	assign qy_c = pwa_pkg::trunc_coord(sy_s5);
	assign addr_ok_c = (32'(tag_s5.col) < pwa_pkg::MAX_WIDTH)
		&& (32'(tag_s5.row) < pwa_pkg::MAX_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			wout <= '0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			wout.valid       <= v_s5;
			wout.req_type    <= tag_s5.req_type;
			wout.pixel_value <= tag_s5.pixel_value;
			wout.addr_ok     <= addr_ok_c;
			wout.addr        <= pwa_pkg::ADDR_BITS'(tag_s5.col)
				+ pwa_pkg::ADDR_BITS'(32'(tag_s5.row) * pwa_pkg::MAX_WIDTH);
			wout.in_frame    <= pwa_pkg::coord_ok(qx_c, frame_w)
				&& pwa_pkg::coord_ok(qy_c, frame_h);
			wout.src_addr    <= pwa_pkg::ADDR_BITS'(qx_c[pwa_pkg::COL_BITS-1:0])
				+ pwa_pkg::ADDR_BITS'(32'(qy_c[pwa_pkg::ROW_BITS-1:0]) * pwa_pkg::MAX_WIDTH);
		end
	end

	always_ff @(posedge clk) begin
		tag_s1.req_type    <= cmd.req_type;
		tag_s1.col         <= cmd.col;
		tag_s1.row         <= cmd.row;
		tag_s1.pixel_value <= pwa_pkg::PIXEL_BITS'(cmd.pixel_value);
		cax_s1  <= cmd.coef_axis;
		cix_s1  <= cmd.coef_index;
		cval_s1 <= cmd.coef_value;
		pc_s1 <= pc_c;
		pr_s1 <= pr_c;

		tag_s2 <= tag_s1;
		cax_s2  <= cax_s1;
		cix_s2  <= cix_s1;
		cval_s2 <= cval_s1;
		for (int t = 0; t < NT; t++)
			mono_s2[t] <= MB'(pc_s1[pwa_pkg::term_i(t)] * pr_s1[pwa_pkg::term_j(t)]);

		tag_s3 <= tag_s2;
		for (int t = 0; t < NT; t++) begin
			px_s3[t] <= x_coef_q[t] * $signed({1'b0, mono_s2[t]});
			py_s3[t] <= y_coef_q[t] * $signed({1'b0, mono_s2[t]});
		end

		tag_s4 <= tag_s3;
		for (int i = 0; i <= DG; i++) begin
			gx_s4[i] <= gx_c[i];
			gy_s4[i] <= gy_c[i];
		end

		tag_s5 <= tag_s4;
		sx_s5  <= sx_c;
		sy_s5  <= sy_c;
	end

endmodule

`default_nettype wire

/* rtl/core/polynomial_warp_accumulate_top.sv */
// ----------------------------------------------------------------------------
// polynomial_warp_accumulate_top
// Image stacker with a 2-D polynomial warp: source/accumulator stores,
// coefficient load, warp pipeline and saturating accumulate.
// ----------------------------------------------------------------------------
// One command word is taken per cycle (start high, busy low) and each word
// produces exactly one result word, shown on result for one cycle with done
// high, in order. The receiver cannot stall, so results must be taken as
// they appear. A word passes the six warp stages (powers, monomials,
// coefficient multiplies, two adder levels, truncate and frame check), then
// one store read stage and the output register.
// After reset the accumulator store is swept to zero, one entry per cycle:
// busy is high until every entry is clear. APB writes are taken throughout.
// Source loads, accumulates and reads of the same pixel are kept in order by
// doing all store access at the end of the pipeline; a one-entry bypass
// covers a read that meets the accumulator write of the word just ahead.
// Active size registers must only be written while no word is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_warp_accumulate_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// command channel
	input  wire logic             start,
	output logic                  busy,
	input  wire pwa_pkg::cmd_t    cmd,
	// result channel
	output logic                  done,
	output pwa_pkg::result_t      result,
	// APB config
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic      [31:0]      prdata,
	output logic                  pready
);

	localparam int AB = pwa_pkg::ADDR_BITS;
	localparam int SW = pwa_pkg::SUM_W;
	localparam int ZB = pwa_pkg::SIZE_BITS;

	// ---------------- configuration ----------------
	logic [ZB-1:0] active_width_q, active_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q  <= ZB'(256);
			active_height_q <= ZB'(256);
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				pwa_pkg::CFG_WIDTH:  active_width_q  <= pwdata[ZB-1:0];
				pwa_pkg::CFG_HEIGHT: active_height_q <= pwdata[ZB-1:0];
				default: ;
			endcase
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == pwa_pkg::CFG_HEIGHT) ? 32'(active_height_q)
		: 32'(active_width_q);

	// effective frame limits, clamped to the store size
	logic [ZB-1:0] frame_w, frame_h;
	assign frame_w = (32'(active_width_q) > pwa_pkg::MAX_WIDTH)
		? ZB'(pwa_pkg::MAX_WIDTH) : active_width_q;
	assign frame_h = (32'(active_height_q) > pwa_pkg::MAX_HEIGHT)
		? ZB'(pwa_pkg::MAX_HEIGHT) : active_height_q;

	// ---------------- clearing pass ----------------
	logic [pwa_pkg::CNT_BITS-1:0] clr_q;
	logic                         clearing;

	assign clearing = (32'(clr_q) != pwa_pkg::NPIX);
	assign busy     = clearing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (clearing) clr_q <= clr_q + pwa_pkg::CNT_BITS'(1);
	end

	// ---------------- warp pipeline (s1..s6) ----------------
	logic               accept;
	pwa_pkg::warp_out_t wout;

	assign accept = start && !busy;

	pwa_warp u_warp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (accept),
		.cmd      (cmd),
		.frame_w  (frame_w),
		.frame_h  (frame_h),
		.wout     (wout)
	);

	// ---------------- stores ----------------
	// source store: written and read only from s6, so words stay ordered
	logic [pwa_pkg::PIXEL_BITS-1:0] src_rdata;

	pwa_ram #(.WIDTH(pwa_pkg::PIXEL_BITS), .DEPTH(pwa_pkg::NPIX)) u_src_ram (
		.clk   (clk),
		.we    (wout.valid && wout.req_type == pwa_pkg::REQ_LOAD && wout.addr_ok),
		.waddr (wout.addr),
		.wdata (wout.pixel_value),
		.raddr (wout.src_addr),
		.rdata (src_rdata)
	);

	// s7 registers
	logic          v_s7;
	pwa_pkg::req_t req_s7;
	logic          addr_ok_s7, in_frame_s7;
	logic [AB-1:0] addr_s7;

	logic          acc_we;
	logic [AB-1:0] acc_waddr;
	logic [SW-1:0] acc_wdata;
	logic [SW-1:0] acc_rdata;

	pwa_ram #(.WIDTH(SW), .DEPTH(pwa_pkg::NPIX)) u_acc_ram (
		.clk   (clk),
		.we    (acc_we),
		.waddr (acc_waddr),
		.wdata (acc_wdata),
		.raddr (wout.addr),
		.rdata (acc_rdata)
	);

	// bypass: last accumulator value written by the pipeline
	logic          byp_v_q;
	logic [AB-1:0] byp_addr_q;
	logic [SW-1:0] byp_data_q;

	logic [SW-1:0] old_sum;
	logic [SW:0]   add_sum;
	logic [SW-1:0] new_sum;
	logic          sat;
	logic          used;

	assign old_sum = (byp_v_q && byp_addr_q == addr_s7) ? byp_data_q : acc_rdata;
	assign add_sum = {1'b0, old_sum} + (SW + 1)'(src_rdata);
	assign sat     = add_sum[SW];
	assign new_sum = sat ? '1 : add_sum[SW-1:0];
	assign used    = v_s7 && req_s7 == pwa_pkg::REQ_ACCUM && addr_ok_s7 && in_frame_s7;

	always_comb begin
		if (clearing) begin
			acc_we    = 1'b1;
			acc_waddr = clr_q[AB-1:0];
			acc_wdata = '0;
		end else begin
			acc_we    = used;
			acc_waddr = addr_s7;
			acc_wdata = new_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7    <= 1'b0;
			byp_v_q <= 1'b0;
			done    <= 1'b0;
		end else begin
			v_s7 <= wout.valid;
			if (used) byp_v_q <= 1'b1;
			done <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		req_s7      <= wout.req_type;
		addr_ok_s7  <= wout.addr_ok;
		in_frame_s7 <= wout.in_frame;
		addr_s7     <= wout.addr;
		if (used) begin
			byp_addr_q <= addr_s7;
			byp_data_q <= new_sum;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		result.source_used   <= used;
		result.sum_saturated <= used && sat;
		if (!addr_ok_s7) begin
			result.pixel_sum <= '0;
		end else begin
			unique case (req_s7)
				pwa_pkg::REQ_ACCUM: result.pixel_sum <= in_frame_s7 ? new_sum : old_sum;
				pwa_pkg::REQ_READ:  result.pixel_sum <= old_sum;
				pwa_pkg::REQ_LOAD,
				pwa_pkg::REQ_COEF:  result.pixel_sum <= '0;
				default:            result.pixel_sum <= '0;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/pwa_checker.sv */
// ----------------------------------------------------------------------------
// pwa_checker
// Port-level checks on word timing and result flags, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pwa_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire pwa_pkg::cmd_t    cmd,
	input wire logic             done,
	input wire pwa_pkg::result_t result
);

	a_done_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, pwa_pkg::LATENCY))
		else $error("result without an accepted word");

	a_word_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		$past(start && !busy, pwa_pkg::LATENCY) |-> done)
		else $error("accepted word produced no result");

	a_sat_needs_used: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.sum_saturated) |-> result.source_used)
		else $error("saturation flagged without accumulate");

	a_used_only_accum: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.source_used)
			|-> ($past(cmd.req_type, pwa_pkg::LATENCY) == pwa_pkg::REQ_ACCUM))
		else $error("source_used on a non-accumulate word");

endmodule

bind polynomial_warp_accumulate_top pwa_checker u_pwa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.cmd    (cmd),
	.done   (done),
	.result (result)
);

`default_nettype wire

/* bench/polynomial_warp_accumulate_top_test.sv */
// ----------------------------------------------------------------------------
// polynomial_warp_accumulate_top_test
// Self-checking bench for the polynomial warp stacker: directed words, random
// warp models across several frame sizes, and a back-to-back burst on one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module polynomial_warp_accumulate_top_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [2:0] REG_ACTIVE_WIDTH  = 3'd0;
	localparam logic [2:0] REG_ACTIVE_HEIGHT = 3'd4;
	localparam int         CYCLE_LIMIT       = 1000000;
	localparam int         BURST_WORDS       = 100;

	// DUT ports
	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	pwa_pkg::cmd_t      cmd;
	logic               done;
	pwa_pkg::result_t   result;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	polynomial_warp_accumulate_top dut (
		.clk(clk), .arst_n(arst_n),
		.start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Words waiting for the driver, and the results they should give.
	pwa_pkg::cmd_t    pending_words[$];
	pwa_pkg::result_t expected_sums[$];

	// Prediction state, advanced only when the DUT accepts a word.
	logic [31:0] accum_mem [0:pwa_pkg::NPIX-1];
	logic [15:0] pix_mem [0:pwa_pkg::NPIX-1];
	longint      x_terms [0:pwa_pkg::NTERMS-1];
	longint      y_terms [0:pwa_pkg::NTERMS-1];
	logic [8:0]  frame_w;
	logic [8:0]  frame_h;

	// Generator shadow: lets the stimulus avoid reading unwritten source pixels.
	bit          gen_written [0:pwa_pkg::NPIX-1];
	longint      gen_x [0:pwa_pkg::NTERMS-1];
	longint      gen_y [0:pwa_pkg::NTERMS-1];
	logic [8:0]  gen_w;
	logic [8:0]  gen_h;

	int  error_count;
	int  cycle_count;
	int  accepted_words;
	int  in_frame_hits;
	int  sat_hits;
	int  gap_left;
	bit  burst_mode;
	bit  no_gaps;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Exact polynomial value, truncated toward zero.
	function automatic longint warp_coord(input longint k [0:pwa_pkg::NTERMS-1],
		input int c, input int r);
		longint s;
		longint m;
		int t;
		s = 0;
		t = 0;
		for (int i = 0; i <= pwa_pkg::DEGREE; i++) begin
			for (int j = 0; j <= pwa_pkg::DEGREE - i; j++) begin
				m = 1;
				for (int n = 0; n < i; n++) m = m * c;
				for (int n = 0; n < j; n++) m = m * r;
				s = s + k[t] * m;
				t++;
			end
		end
		if (s >= 0) return s >>> pwa_pkg::FRAC_BITS;
		return -((-s) >>> pwa_pkg::FRAC_BITS);
	endfunction

	function automatic bit in_frame(input longint q, input logic [8:0] lim,
		input int max_size);
		longint e;
		e = (32'(lim) < max_size) ? longint'(lim) : longint'(max_size);
		return q >= 0 && q < e;
	endfunction

	function automatic longint sext_coef(input logic [pwa_pkg::COEF_BITS-1:0] v);
		return {{(64-pwa_pkg::COEF_BITS){v[pwa_pkg::COEF_BITS-1]}}, v};
	endfunction

	// Random filler for the fields a word kind does not use.
	function automatic pwa_pkg::cmd_t rand_word();
		logic [95:0] b;
		b = {$urandom, $urandom, $urandom};
		return pwa_pkg::cmd_t'(b[$bits(pwa_pkg::cmd_t)-1:0]);
	endfunction

	// Advance the model by one accepted word and queue its result.
	task automatic predict_word(input pwa_pkg::cmd_t w);
		pwa_pkg::result_t r;
		int      a;
		int      src;
		longint  sx;
		longint  sy;
		logic [32:0] s;
		r = '0;
		a = int'(w.col) + int'(w.row) * pwa_pkg::MAX_WIDTH;
		case (w.req_type)
			pwa_pkg::REQ_LOAD: begin
				pix_mem[a] = w.pixel_value;
			end
			pwa_pkg::REQ_COEF: begin
				if (int'(w.coef_index) < pwa_pkg::NTERMS) begin
					if (w.coef_axis) y_terms[w.coef_index] = sext_coef(w.coef_value);
					else x_terms[w.coef_index] = sext_coef(w.coef_value);
				end
			end
			pwa_pkg::REQ_ACCUM: begin
				sx = warp_coord(x_terms, int'(w.col), int'(w.row));
				sy = warp_coord(y_terms, int'(w.col), int'(w.row));
				if (in_frame(sx, frame_w, pwa_pkg::MAX_WIDTH)
						&& in_frame(sy, frame_h, pwa_pkg::MAX_HEIGHT)) begin
					src = int'(sx) + int'(sy) * pwa_pkg::MAX_WIDTH;
					s = {1'b0, accum_mem[a]} + {17'b0, pix_mem[src]};
					if (s[32]) begin
						s = 33'hFFFFFFFF;
						r.sum_saturated = 1'b1;
						sat_hits++;
					end
					accum_mem[a] = s[31:0];
					r.source_used = 1'b1;
					in_frame_hits++;
				end
				r.pixel_sum = accum_mem[a];
			end
			default: begin
				r.pixel_sum = accum_mem[a];
			end
		endcase
		expected_sums.push_back(r);
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle_count);
		error_count++;
	endtask

	// Driver: one word at a time, random gap after each acceptance outside bursts.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				predict_word(cmd);
				accepted_words++;
			end
			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (pending_words.size() > 0) begin
					cmd <= pending_words.pop_front();
					start <= 1'b1;
					if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
					gap_left = (no_gaps || burst_mode) ? 0 : int'($urandom_range(0, 17));
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: every strobed result word against the oldest expectation.
	always @(posedge clk) begin
		pwa_pkg::result_t want;
		if (arst_n && done) begin
			if (expected_sums.size() == 0) begin
				report_mismatch("unexpected result word", longint'(result), 0);
			end else begin
				want = expected_sums.pop_front();
				if (result.pixel_sum !== want.pixel_sum)
					report_mismatch("pixel_sum", result.pixel_sum, want.pixel_sum);
				if (result.source_used !== want.source_used)
					report_mismatch("source_used", result.source_used, want.source_used);
				if (result.sum_saturated !== want.sum_saturated)
					report_mismatch("sum_saturated", result.sum_saturated, want.sum_saturated);
			end
		end
	end

	// Watchdog covers the post-reset sweep, the burst and all gaps.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// ---- stimulus helpers: all keep the generator shadow in step ----

	task automatic push_load(input int c, input int r, input logic [15:0] v);
		pwa_pkg::cmd_t w;
		w = rand_word();
		w.req_type = pwa_pkg::REQ_LOAD;
		w.col = 8'(c);
		w.row = 8'(r);
		w.pixel_value = v;
		gen_written[c + r * pwa_pkg::MAX_WIDTH] = 1'b1;
		pending_words.push_back(w);
	endtask

	task automatic push_coef(input bit axis, input int idx, input longint v);
		pwa_pkg::cmd_t w;
		w = rand_word();
		w.req_type = pwa_pkg::REQ_COEF;
		w.coef_axis = axis;
		w.coef_index = 4'(idx);
		w.coef_value = v[pwa_pkg::COEF_BITS-1:0];
		if (idx < pwa_pkg::NTERMS) begin
			if (axis) gen_y[idx] = sext_coef(w.coef_value);
			else gen_x[idx] = sext_coef(w.coef_value);
		end
		pending_words.push_back(w);
	endtask

	// Accumulate; a never-written in-frame source gets a load first.
	task automatic push_accum(input int c, input int r);
		pwa_pkg::cmd_t w;
		longint sx;
		longint sy;
		sx = warp_coord(gen_x, c, r);
		sy = warp_coord(gen_y, c, r);
		if (in_frame(sx, gen_w, pwa_pkg::MAX_WIDTH)
				&& in_frame(sy, gen_h, pwa_pkg::MAX_HEIGHT)
				&& !gen_written[int'(sx) + int'(sy) * pwa_pkg::MAX_WIDTH])
			push_load(int'(sx), int'(sy), 16'($urandom));
		w = rand_word();
		w.req_type = pwa_pkg::REQ_ACCUM;
		w.col = 8'(c);
		w.row = 8'(r);
		pending_words.push_back(w);
	endtask

	task automatic push_read(input int c, input int r);
		pwa_pkg::cmd_t w;
		w = rand_word();
		w.req_type = pwa_pkg::REQ_READ;
		w.col = 8'(c);
		w.row = 8'(r);
		pending_words.push_back(w);
	endtask

	// Near-identity warp: a shift plus small linear and quadratic terms.
	task automatic push_warp_model();
		longint one;
		one = longint'(1) <<< pwa_pkg::FRAC_BITS;
		for (int ax = 0; ax < 2; ax++) begin
			for (int t = 0; t < pwa_pkg::NTERMS; t++) begin
				longint v;
				if (t == 0)
					v = longint'($signed($urandom_range(0, 80)) - 40) * one
						+ longint'($urandom_range(0, (1 << pwa_pkg::FRAC_BITS) - 1));
				else if (t == 1 || t == 3)
					v = (((ax == 1) == (t == 1)) ? one : 0)
						+ longint'($signed($urandom_range(0, 1 << 22))) - (1 << 21);
				else
					v = longint'($signed($urandom_range(0, 1 << 9))) - (1 << 8);
				push_coef(ax[0], t, v);
			end
		end
	endtask

	// Wait until nothing is in flight, then let the pipeline empty.
	task automatic wait_idle();
		while (pending_words.size() > 0 || start || expected_sums.size() > 0)
			@(posedge clk);
		repeat (pwa_pkg::LATENCY + 4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle; pready is always high.
	task automatic apb_write(input logic [2:0] a, input logic [31:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (a == REG_ACTIVE_WIDTH) begin
			frame_w = d[8:0];
			gen_w = d[8:0];
		end else begin
			frame_h = d[8:0];
			gen_h = d[8:0];
		end
	endtask

	task automatic set_frame(input logic [31:0] w, input logic [31:0] h);
		wait_idle();
		apb_write(REG_ACTIVE_WIDTH, w);
		apb_write(REG_ACTIVE_HEIGHT, h);
	endtask

	// One random phase of mostly well-formed traffic.
	task automatic random_phase(input int n);
		int k;
		for (k = 0; k < n; k++) begin
			int pick;
			pick = int'($urandom_range(0, 99));
			if (pick < 3) begin
				push_warp_model();
			end else if (pick < 7) begin
				// noise: out-of-range term numbers and raw coefficients
				push_coef(1'($urandom_range(0, 1)), int'($urandom_range(0, 15)),
					longint'({$urandom, $urandom}));
			end else if (pick < 30) begin
				push_load(int'($urandom_range(0, 255)), int'($urandom_range(0, 255)),
					16'($urandom));
			end else if (pick < 80) begin
				if ($urandom_range(0, 1))
					push_accum(int'($urandom_range(0, 255)), int'($urandom_range(0, 255)));
				else
					push_accum(int'($urandom_range(0, 15)), int'($urandom_range(0, 15)));
			end else begin
				push_read(int'($urandom_range(0, 255)), int'($urandom_range(0, 255)));
			end
		end
	endtask

	initial begin
		longint one;
		one = longint'(1) <<< pwa_pkg::FRAC_BITS;
		error_count = 0;
		cycle_count = 0;
		accepted_words = 0;
		in_frame_hits = 0;
		sat_hits = 0;
		gap_left = 0;
		burst_mode = 1'b0;
		no_gaps = 1'b0;
		for (int i = 0; i < pwa_pkg::NPIX; i++) begin
			accum_mem[i] = '0;
			pix_mem[i] = '0;
			gen_written[i] = 1'b0;
		end
		for (int t = 0; t < pwa_pkg::NTERMS; t++) begin
			x_terms[t] = 0;
			y_terms[t] = 0;
			gen_x[t] = 0;
			gen_y[t] = 0;
		end
		frame_w = 9'd256;
		frame_h = 9'd256;
		gen_w = 9'd256;
		gen_h = 9'd256;
		start = 1'b0;
		cmd = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: corners, every word kind, ignored term number, extremes.
		apb_write(REG_ACTIVE_WIDTH, 32'd256);
		apb_write(REG_ACTIVE_HEIGHT, 32'd256);
		push_read(255, 255);
		push_load(0, 0, 16'hFFFF);
		push_load(255, 255, 16'h0000);
		push_accum(0, 0);
		push_accum(255, 255);
		push_coef(1'b0, 3, one);
		push_coef(1'b1, 1, one);
		push_accum(255, 255);
		push_accum(17, 200);
		push_read(17, 200);
		push_coef(1'b0, 15, 64'h7F_FFFF_FFFF);
		push_coef(1'b1, pwa_pkg::NTERMS, 64'h80_0000_0000);
		push_accum(3, 3);
		push_coef(1'b0, 0, 64'hFFFF_FF80_0000_0000);
		push_accum(3, 3);
		push_coef(1'b1, 5, 64'h7F_FFFF_FFFF);
		push_accum(200, 10);
		push_coef(1'b0, 0, -(one >>> 1));
		push_coef(1'b1, 5, 0);
		push_accum(0, 9);
		push_accum(1, 9);
		push_read(0, 0);

		// Frame sizes: full, minimum, zero, oversize, random; each drain is a
		// full hold-off until every expected word has come back.
		random_phase(150);
		set_frame(32'd1, 32'd1);
		push_warp_model();
		random_phase(150);
		set_frame(32'd0, 32'd256);
		random_phase(100);
		set_frame(32'h1FF, 32'd0);
		random_phase(100);
		set_frame(32'hFFFF_FE00 | 32'd300, 32'h1FF);
		random_phase(150);
		set_frame($urandom_range(1, 256), $urandom_range(1, 256));
		random_phase(150);
		set_frame(32'd256, 32'd256);
		random_phase(100);

		// Burst: the same output pixel back to back, no gaps, so every
		// accumulate after the first meets the write of the one just ahead.
		wait_idle();
		no_gaps = 1'b1;
		for (int t = 0; t < pwa_pkg::NTERMS; t++) begin
			push_coef(1'b0, t, (t == 3) ? one : 0);
			push_coef(1'b1, t, (t == 1) ? one : 0);
		end
		push_load(5, 5, 16'hFFFF);
		for (int k = 0; k < BURST_WORDS; k++) push_accum(5, 5);
		push_read(5, 5);

		wait_idle();
		repeat (4 * pwa_pkg::LATENCY) @(posedge clk);
		$display("run: %0d words accepted, %0d in-frame accumulates, %0d saturated",
			accepted_words, in_frame_hits, sat_hits);
		$display("frame sizes full, one pixel, zero, oversize and random were exercised");
		if (error_count == 0 && expected_sums.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

`default_nettype wire

/* polynomial_warp_accumulate_top.f */
rtl/core/pwa_pkg.sv
rtl/core/pwa_ram.sv
rtl/core/pwa_warp.sv
rtl/core/polynomial_warp_accumulate_top.sv
rtl/core/pwa_checker.sv
bench/polynomial_warp_accumulate_top_test.sv
